// ===== hw/rtl/qvr_pkg.sv =====
package qvr_pkg;

  localparam int QUAT_WIDTH_DEF = 16;
  localparam int VEC_WIDTH_DEF  = 16;

  // control that travels with each item down the pipe
  typedef struct packed {
    logic       valid;
    logic       zero_length;
    logic [2:0] neg;
  } ctl_t;

endpackage

// ===== hw/rtl/qvr_hamilton.sv =====
module qvr_hamilton
  import qvr_pkg::*;
#(
  parameter int QW = QUAT_WIDTH_DEF,
  parameter int VW = VEC_WIDTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  input  logic signed [QW-1:0] quat_x,
  input  logic signed [QW-1:0] quat_y,
  input  logic signed [QW-1:0] quat_z,
  input  logic signed [QW-1:0] quat_w,
  input  logic signed [VW-1:0] vec_x,
  input  logic signed [VW-1:0] vec_y,
  input  logic signed [VW-1:0] vec_z,
  output ctl_t                 ctl,
  output logic [2*QW+VW+5:0]   num_x,
  output logic [2*QW+VW+5:0]   num_y,
  output logic [2*QW+VW+5:0]   num_z,
  output logic [2*QW+1:0]      den
);

  localparam int PW  = QW + VW;
  localparam int TW  = QW + VW + 2;
  localparam int P2W = TW + QW;
  localparam int RW  = P2W + 2;
  localparam int NW  = RW + 2;
  localparam int LW  = 2 * QW + 1;

  // stage a: first product terms and squares
  logic                 va;
  logic signed [QW-1:0] aq_x, aq_y, aq_z, aq_w;
  logic signed [PW-1:0] pa [0:11];
  logic signed [2*QW-1:0] sq [0:3];

  always_ff @(posedge clk) begin
    if (rst) va <= 1'b0;
    else va <= in_valid;
    aq_x <= quat_x;
    aq_y <= quat_y;
    aq_z <= quat_z;
    aq_w <= quat_w;
    pa[0]  <= quat_w * vec_x;
    pa[1]  <= quat_w * vec_y;
    pa[2]  <= quat_w * vec_z;
    pa[3]  <= quat_y * vec_z;
    pa[4]  <= quat_z * vec_y;
    pa[5]  <= quat_z * vec_x;
    pa[6]  <= quat_x * vec_z;
    pa[7]  <= quat_x * vec_y;
    pa[8]  <= quat_y * vec_x;
    pa[9]  <= quat_x * vec_x;
    pa[10] <= quat_y * vec_y;
    pa[11] <= quat_z * vec_z;
    sq[0]  <= quat_x * quat_x;
    sq[1]  <= quat_y * quat_y;
    sq[2]  <= quat_z * quat_z;
    sq[3]  <= quat_w * quat_w;
  end

  // stage b: t = conj(q) * p, and squared length
  logic                 vb;
  logic signed [QW-1:0] bq_x, bq_y, bq_z, bq_w;
  logic signed [TW-1:0] t_x, t_y, t_z, t_w;
  logic [LW-1:0]        len_b;

  always_ff @(posedge clk) begin
    if (rst) vb <= 1'b0;
    else vb <= va;
    bq_x <= aq_x;
    bq_y <= aq_y;
    bq_z <= aq_z;
    bq_w <= aq_w;
    t_x <= TW'(pa[0]) - TW'(pa[3]) + TW'(pa[4]);
    t_y <= TW'(pa[1]) - TW'(pa[5]) + TW'(pa[6]);
    t_z <= TW'(pa[2]) - TW'(pa[7]) + TW'(pa[8]);
    t_w <= TW'(pa[9]) + TW'(pa[10]) + TW'(pa[11]);
    len_b <= LW'($unsigned(sq[0])) + LW'($unsigned(sq[1]))
           + LW'($unsigned(sq[2])) + LW'($unsigned(sq[3]));
  end

  // stage c: second product terms t * q
  logic                  vc;
  logic signed [P2W-1:0] pc [0:11];
  logic [LW-1:0]         len_c;

  always_ff @(posedge clk) begin
    if (rst) vc <= 1'b0;
    else vc <= vb;
    len_c  <= len_b;
    pc[0]  <= t_x * bq_w;
    pc[1]  <= t_w * bq_x;
    pc[2]  <= t_y * bq_z;
    pc[3]  <= t_z * bq_y;
    pc[4]  <= t_y * bq_w;
    pc[5]  <= t_w * bq_y;
    pc[6]  <= t_z * bq_x;
    pc[7]  <= t_x * bq_z;
    pc[8]  <= t_z * bq_w;
    pc[9]  <= t_w * bq_z;
    pc[10] <= t_x * bq_y;
    pc[11] <= t_y * bq_x;
  end

  // stage d: vector part of the raw product, rounding offset folded in
  logic signed [RW-1:0] r_x, r_y, r_z;
  logic [NW-1:0]        m_x, m_y, m_z;

  always_comb begin
    r_x = RW'(pc[0]) + RW'(pc[1]) + RW'(pc[2]) - RW'(pc[3]);
    r_y = RW'(pc[4]) + RW'(pc[5]) + RW'(pc[6]) - RW'(pc[7]);
    r_z = RW'(pc[8]) + RW'(pc[9]) + RW'(pc[10]) - RW'(pc[11]);
    m_x = r_x[RW-1] ? NW'($unsigned(-r_x)) : NW'($unsigned(r_x));
    m_y = r_y[RW-1] ? NW'($unsigned(-r_y)) : NW'($unsigned(r_y));
    m_z = r_z[RW-1] ? NW'($unsigned(-r_z)) : NW'($unsigned(r_z));
  end

  always_ff @(posedge clk) begin
    if (rst) ctl <= '0;
    else begin
      ctl.valid       <= vc;
      ctl.zero_length <= (len_c == '0);
      ctl.neg         <= {r_z[RW-1], r_y[RW-1], r_x[RW-1]};
    end
    num_x <= (m_x << 1) + NW'(len_c);
    num_y <= (m_y << 1) + NW'(len_c);
    num_z <= (m_z << 1) + NW'(len_c);
    den   <= {len_c, 1'b0};
  end

endmodule

// ===== hw/rtl/qvr_divider.sv =====
module qvr_divider
  import qvr_pkg::*;
#(
  parameter int QW = QUAT_WIDTH_DEF,
  parameter int VW = VEC_WIDTH_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  ctl_t               in_ctl,
  input  logic [2*QW+VW+5:0] num_x,
  input  logic [2*QW+VW+5:0] num_y,
  input  logic [2*QW+VW+5:0] num_z,
  input  logic [2*QW+1:0]    den,
  output ctl_t               out_ctl,
  output logic [VW:0]        quot_x,
  output logic [VW:0]        quot_y,
  output logic [VW:0]        quot_z
);

  localparam int NW = 2 * QW + VW + 6;
  localparam int DW = 2 * QW + 2;
  localparam int QB = VW + 1;
  localparam int EW = NW + QB + 1;

  // one restoring quotient bit per stage, three lanes side by side
  ctl_t          s_ctl [1:QB];
  logic [DW-1:0] s_den [1:QB-1];
  logic [NW-1:0] s_rem [1:QB-1][0:2];
  logic [QB-1:0] s_quo [1:QB][0:2];
  logic [NW-1:0] num_in [0:2];

  assign num_in[0] = num_x;
  assign num_in[1] = num_y;
  assign num_in[2] = num_z;

  for (genvar s = 0; s < QB; s++) begin : g_stage
    localparam int K = QB - 1 - s;
    ctl_t          c_in;
    logic [DW-1:0] d_in;
    logic [EW-1:0] trial;

    if (s == 0) begin : g_first
      assign c_in = in_ctl;
      assign d_in = den;
    end else begin : g_next
      assign c_in = s_ctl[s];
      assign d_in = s_den[s];
    end

    assign trial = EW'(d_in) << K;

    always_ff @(posedge clk) begin
      if (rst) s_ctl[s+1] <= '0;
      else s_ctl[s+1] <= c_in;
    end

    if (s < QB - 1) begin : g_den
      always_ff @(posedge clk) begin
        s_den[s+1] <= d_in;
      end
    end

    for (genvar l = 0; l < 3; l++) begin : g_lane
      logic [NW-1:0] r_in;
      logic [QB-1:0] q_in;
      logic          take;

      if (s == 0) begin : g_first
        assign r_in = num_in[l];
        assign q_in = '0;
      end else begin : g_next
        assign r_in = s_rem[s][l];
        assign q_in = s_quo[s][l];
      end

      assign take = EW'(r_in) >= trial;

      always_ff @(posedge clk) begin
        s_quo[s+1][l] <= q_in | (QB'(take) << K);
      end

      if (s < QB - 1) begin : g_rem
        always_ff @(posedge clk) begin
          s_rem[s+1][l] <= take ? NW'(EW'(r_in) - trial) : r_in;
        end
      end
    end
  end

  assign out_ctl = s_ctl[QB];
  assign quot_x  = s_quo[QB][0];
  assign quot_y  = s_quo[QB][1];
  assign quot_z  = s_quo[QB][2];

endmodule

// ===== hw/rtl/quaternion_vector_rotate.sv =====
// channel   signals                                  transfer
// input     start, busy, quat_x..quat_w, vec_x..z    start high, busy low
// result    done, rot_x..rot_z, zero_length, sat.    done high for one cycle
//
// one item per cycle; each result passes from its transfer through
// four multiply/add stages, one stage per quotient bit of the rounded divide
// by the squared length, and the clamp/output register
// busy is always low and the result side never stalls
// rst is synchronous; it empties the pipe, items in flight are dropped
module quaternion_vector_rotate
  import qvr_pkg::*;
#(
  parameter int QUAT_WIDTH = QUAT_WIDTH_DEF,
  parameter int VEC_WIDTH  = VEC_WIDTH_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  output logic                         busy,
  input  logic signed [QUAT_WIDTH-1:0] quat_x,
  input  logic signed [QUAT_WIDTH-1:0] quat_y,
  input  logic signed [QUAT_WIDTH-1:0] quat_z,
  input  logic signed [QUAT_WIDTH-1:0] quat_w,
  input  logic signed [VEC_WIDTH-1:0]  vec_x,
  input  logic signed [VEC_WIDTH-1:0]  vec_y,
  input  logic signed [VEC_WIDTH-1:0]  vec_z,
  output logic                         done,
  output logic signed [VEC_WIDTH-1:0]  rot_x,
  output logic signed [VEC_WIDTH-1:0]  rot_y,
  output logic signed [VEC_WIDTH-1:0]  rot_z,
  output logic                         zero_length,
  output logic                         saturated
);

  localparam int QW  = QUAT_WIDTH;
  localparam int VW  = VEC_WIDTH;
  localparam int NW  = 2 * QW + VW + 6;
  localparam int DW  = 2 * QW + 2;
  localparam int SW  = VW + 2;
  localparam int LAT = VW + 6;
  localparam logic signed [SW-1:0] HI = SW'((1 << (VW - 1)) - 1);
  localparam logic signed [SW-1:0] LO = -HI - SW'(1);

  ctl_t          h_ctl, d_ctl;
  logic [NW-1:0] num_x, num_y, num_z;
  logic [DW-1:0] den;
  logic [VW:0]   quot_x, quot_y, quot_z;

  assign busy = 1'b0;

  qvr_hamilton #(.QW(QW), .VW(VW)) u_ham (
    .clk, .rst,
    .in_valid (start && !busy),
    .quat_x, .quat_y, .quat_z, .quat_w,
    .vec_x, .vec_y, .vec_z,
    .ctl   (h_ctl),
    .num_x, .num_y, .num_z,
    .den
  );

  qvr_divider #(.QW(QW), .VW(VW)) u_div (
    .clk, .rst,
    .in_ctl  (h_ctl),
    .num_x, .num_y, .num_z,
    .den,
    .out_ctl (d_ctl),
    .quot_x, .quot_y, .quot_z
  );

  logic signed [SW-1:0] s_x, s_y, s_z;
  logic [2:0]           over, under;

  always_comb begin
    s_x = d_ctl.neg[0] ? -SW'(quot_x) : SW'(quot_x);
    s_y = d_ctl.neg[1] ? -SW'(quot_y) : SW'(quot_y);
    s_z = d_ctl.neg[2] ? -SW'(quot_z) : SW'(quot_z);
    over  = {s_z > HI, s_y > HI, s_x > HI};
    under = {s_z < LO, s_y < LO, s_x < LO};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done        <= 1'b0;
      zero_length <= 1'b0;
      saturated   <= 1'b0;
      rot_x       <= '0;
      rot_y       <= '0;
      rot_z       <= '0;
    end else begin
      done        <= d_ctl.valid;
      zero_length <= d_ctl.valid && d_ctl.zero_length;
      saturated   <= d_ctl.valid && !d_ctl.zero_length && ((over | under) != '0);
      if (!d_ctl.valid || d_ctl.zero_length) begin
        rot_x <= '0;
        rot_y <= '0;
        rot_z <= '0;
      end else begin
        rot_x <= over[0] ? VW'(HI) : under[0] ? VW'(LO) : VW'(s_x);
        rot_y <= over[1] ? VW'(HI) : under[1] ? VW'(LO) : VW'(s_y);
        rot_z <= over[2] ? VW'(HI) : under[2] ? VW'(LO) : VW'(s_z);
      end
    end
  end

  a_latency: assert property (@(posedge clk) disable iff (rst)
    start |-> ##LAT done) else $error("result missing after transfer");

  a_zero: assert property (@(posedge clk) disable iff (rst)
    zero_length |-> (done && !saturated && rot_x == '0 && rot_y == '0 && rot_z == '0))
    else $error("zero-length result not cleared");

  a_idle: assert property (@(posedge clk) disable iff (rst)
    !done |-> (!zero_length && !saturated)) else $error("flag without result");

  a_sat: assert property (@(posedge clk) disable iff (rst)
    saturated |-> (rot_x == VW'(HI) || rot_x == VW'(LO) || rot_y == VW'(HI)
                   || rot_y == VW'(LO) || rot_z == VW'(HI) || rot_z == VW'(LO)))
    else $error("saturated without a clamped component");

endmodule
